// File: src/nfpe_pkg.sv
// nfpe_pkg: shared sizes, codes, command and status types of the
// nibble framebuffer pixel engine. No dependencies.

package nfpe_pkg;

    // Screen geometry
    localparam int SCREEN_SIDE  = 128;
    localparam int ROW_BYTES    = (SCREEN_SIDE + 1) / 2;
    localparam int SCREEN_BYTES = SCREEN_SIDE * ROW_BYTES;
    localparam int ADDR_W       = $clog2(SCREEN_BYTES);
    localparam int COORD_W      = $clog2(SCREEN_SIDE);

    // Field widths
    localparam int REQ_W   = 2;
    localparam int POS_W   = 16;
    localparam int COLOR_W = 4;
    localparam int BYTE_W  = 2 * COLOR_W;
    localparam int PAL_W   = 40;
    localparam int ENTRY_W = 5;
    localparam int CFG_IDX_W = 1;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Request codes on req_type
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_GET   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_HIGH = 1'b1;

    // Identity palette after reset
    localparam logic [PAL_W-1:0] PAL_LOW_RESET  = 40'd247132686368;
    localparam logic [PAL_W-1:0] PAL_HIGH_RESET = 40'd530877622568;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SET,
        OP_GET,
        OP_NONE
    } op_t;

    // One classified request
    typedef struct packed {
        op_t                op;
        logic               hit;    // set: write needed; get: on screen
        logic               hi;     // odd x, high nibble
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;  // mapped color for set, fill for clear
    } cmd_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_CLEAR,
        BK_RMW,
        BK_GET
    } bk_state_t;

    typedef struct packed {
        bk_state_t state;
        logic      init_busy;
    } bk_status_t;

endpackage

// File: src/nfpe_ram.sv
// nfpe_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.

module nfpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/nfpe_front.sv
// nfpe_front: accepts requests, holds palette and pen, clips and maps
// color, and emits one classified command per transfer. Uses nfpe_pkg.

module nfpe_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nfpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nfpe_pkg::PAL_W-1:0]          cfg_data,
    input  logic                                accept,
    input  logic [nfpe_pkg::REQ_W-1:0]          req_type,
    input  logic signed [nfpe_pkg::POS_W-1:0]   x_pos,
    input  logic signed [nfpe_pkg::POS_W-1:0]   y_pos,
    input  logic [nfpe_pkg::COLOR_W-1:0]        color_in,
    input  logic                                color_given,
    output nfpe_pkg::cmd_t                      cmd
);

    logic [nfpe_pkg::PAL_W-1:0]   pal_low_reg,  pal_low_next;
    logic [nfpe_pkg::PAL_W-1:0]   pal_high_reg, pal_high_next;
    logic [nfpe_pkg::COLOR_W-1:0] pen_reg,      pen_next;

    logic [nfpe_pkg::COLOR_W-1:0] set_color;
    logic [nfpe_pkg::PAL_W-1:0]   pal_word;
    logic [nfpe_pkg::ENTRY_W-1:0] entry;
    logic                         on_x, on_y, on_screen;
    logic [nfpe_pkg::COORD_W-1:0] x_c, y_c;

    always_comb
    begin
        pal_low_next  = pal_low_reg;
        pal_high_next = pal_high_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                nfpe_pkg::CFG_PALETTE_LOW:  pal_low_next  = cfg_data;
                nfpe_pkg::CFG_PALETTE_HIGH: pal_high_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign set_color = color_given ? color_in : pen_reg;

    // set always updates pen; clear only when a color was given
    always_comb
    begin
        pen_next = pen_reg;
        if (accept)
        begin
            if (req_type == nfpe_pkg::REQ_SET)
            begin
                pen_next = set_color;
            end
            else if (req_type == nfpe_pkg::REQ_CLEAR && color_given)
            begin
                pen_next = color_in;
            end
        end
    end

    // clip: non-negative and below the side
    assign on_x = !x_pos[nfpe_pkg::POS_W-1] &&
                  (x_pos[nfpe_pkg::POS_W-2:0] < (nfpe_pkg::POS_W-1)'(nfpe_pkg::SCREEN_SIDE));
    assign on_y = !y_pos[nfpe_pkg::POS_W-1] &&
                  (y_pos[nfpe_pkg::POS_W-2:0] < (nfpe_pkg::POS_W-1)'(nfpe_pkg::SCREEN_SIDE));
    assign on_screen = on_x && on_y;

    assign x_c = x_pos[nfpe_pkg::COORD_W-1:0];
    assign y_c = y_pos[nfpe_pkg::COORD_W-1:0];

    assign pal_word = set_color[nfpe_pkg::COLOR_W-1] ? pal_high_reg : pal_low_reg;
    assign entry    = pal_word[nfpe_pkg::ENTRY_W * set_color[2:0] +: nfpe_pkg::ENTRY_W];

    always_comb
    begin
        cmd.hi    = x_c[0];
        cmd.addr  = nfpe_pkg::ADDR_W'(y_c) * nfpe_pkg::ADDR_W'(nfpe_pkg::ROW_BYTES)
                  + nfpe_pkg::ADDR_W'(x_c >> 1);
        cmd.hit   = 1'b0;
        cmd.color = '0;
        unique case (req_type)
            nfpe_pkg::REQ_CLEAR:
            begin
                cmd.op    = nfpe_pkg::OP_CLEAR;
                cmd.color = color_given ? color_in : '0;
            end
            nfpe_pkg::REQ_SET:
            begin
                cmd.op    = nfpe_pkg::OP_SET;
                cmd.hit   = on_screen && !entry[nfpe_pkg::ENTRY_W-1];
                cmd.color = entry[nfpe_pkg::COLOR_W-1:0];
            end
            nfpe_pkg::REQ_GET:
            begin
                cmd.op  = nfpe_pkg::OP_GET;
                cmd.hit = on_screen;
            end
            default:
            begin
                cmd.op = nfpe_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_low_reg  <= nfpe_pkg::PAL_LOW_RESET;
            pal_high_reg <= nfpe_pkg::PAL_HIGH_RESET;
            pen_reg      <= '0;
        end
        else
        begin
            pal_low_reg  <= pal_low_next;
            pal_high_reg <= pal_high_next;
            pen_reg      <= pen_next;
        end
    end

endmodule

// File: src/nfpe_queue.sv
// nfpe_queue: short command FIFO between front and back.
// Uses nfpe_pkg (cmd_t, Q_DEPTH).

module nfpe_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  nfpe_pkg::cmd_t                push_cmd,
    input  logic                          pop,
    output nfpe_pkg::cmd_t                head_cmd,
    output logic                          empty,
    output logic                          full,
    output logic [nfpe_pkg::Q_CNT_W-1:0]  count
);

    nfpe_pkg::cmd_t                 slot_reg [nfpe_pkg::Q_DEPTH];
    logic [nfpe_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [nfpe_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [nfpe_pkg::Q_CNT_W-1:0]   count_reg,  count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == nfpe_pkg::Q_CNT_W'(nfpe_pkg::Q_DEPTH));
    assign count    = count_reg;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/nfpe_back.sv
// nfpe_back: executes commands against the screen RAM (sweep, nibble
// read-modify-write, read) and holds the result register.
// Uses nfpe_pkg and nfpe_ram.

module nfpe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nfpe_pkg::cmd_t                head_cmd,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nfpe_pkg::COLOR_W-1:0]  pixel_value,
    output logic                          pixel_written,
    output nfpe_pkg::bk_status_t          status
);

    nfpe_pkg::bk_state_t            state_reg, state_next;
    nfpe_pkg::cmd_t                 cmd_reg,   cmd_next;
    logic [nfpe_pkg::ADDR_W-1:0]    cnt_reg,   cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic [nfpe_pkg::COLOR_W-1:0]   value_reg,     value_next;
    logic                           written_reg,   written_next;

    logic                           ram_we;
    logic [nfpe_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [nfpe_pkg::BYTE_W-1:0]    ram_wdata, ram_rdata;

    logic                           can_issue, sweep_last;
    logic                           out_load;
    logic [nfpe_pkg::COLOR_W-1:0]   out_value;
    logic                           out_written;

    // the result slot is free now or frees at this edge
    assign can_issue  = !q_empty && (!out_valid_reg || out_ready);
    assign sweep_last = (cnt_reg == nfpe_pkg::ADDR_W'(nfpe_pkg::SCREEN_BYTES - 1));

    nfpe_ram #(
        .WIDTH (nfpe_pkg::BYTE_W),
        .DEPTH (nfpe_pkg::SCREEN_BYTES)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfpe_pkg::BK_INIT,
            nfpe_pkg::BK_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = nfpe_pkg::BK_IDLE;
                end
            end
            nfpe_pkg::BK_IDLE:
            begin
                if (can_issue)
                begin
                    unique case (head_cmd.op)
                        nfpe_pkg::OP_CLEAR: state_next = nfpe_pkg::BK_CLEAR;
                        nfpe_pkg::OP_SET:
                            state_next = head_cmd.hit ? nfpe_pkg::BK_RMW : nfpe_pkg::BK_IDLE;
                        nfpe_pkg::OP_GET:
                            state_next = head_cmd.hit ? nfpe_pkg::BK_GET : nfpe_pkg::BK_IDLE;
                        default: state_next = nfpe_pkg::BK_IDLE;
                    endcase
                end
            end
            nfpe_pkg::BK_RMW,
            nfpe_pkg::BK_GET:
            begin
                state_next = nfpe_pkg::BK_IDLE;
            end
            default: state_next = nfpe_pkg::BK_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg;
        ram_wdata   = '0;
        ram_raddr   = head_cmd.addr;
        out_load    = 1'b0;
        out_value   = '0;
        out_written = 1'b0;
        cmd_next    = cmd_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            nfpe_pkg::BK_INIT:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            nfpe_pkg::BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {cmd_reg.color, cmd_reg.color};
                cnt_next  = cnt_reg + 1'b1;
                out_load  = sweep_last;
            end
            nfpe_pkg::BK_IDLE:
            begin
                if (can_issue)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    cnt_next = '0;
                    // no memory work: result is zeros right away
                    out_load = (head_cmd.op != nfpe_pkg::OP_CLEAR) && !head_cmd.hit;
                end
            end
            nfpe_pkg::BK_RMW:
            begin
                ram_we      = 1'b1;
                ram_waddr   = cmd_reg.addr;
                ram_wdata   = cmd_reg.hi ? {cmd_reg.color, ram_rdata[nfpe_pkg::COLOR_W-1:0]}
                                         : {ram_rdata[nfpe_pkg::BYTE_W-1:nfpe_pkg::COLOR_W],
                                            cmd_reg.color};
                out_load    = 1'b1;
                out_written = 1'b1;
            end
            nfpe_pkg::BK_GET:
            begin
                out_load  = 1'b1;
                out_value = cmd_reg.hi ? ram_rdata[nfpe_pkg::BYTE_W-1:nfpe_pkg::COLOR_W]
                                       : ram_rdata[nfpe_pkg::COLOR_W-1:0];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        written_next   = written_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            value_next     = out_value;
            written_next   = out_written;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfpe_pkg::BK_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        value_reg   <= value_next;
        written_reg <= written_next;
    end

    assign out_valid        = out_valid_reg;
    assign pixel_value      = value_reg;
    assign pixel_written    = written_reg;
    assign status.state     = state_reg;
    assign status.init_busy = (state_reg == nfpe_pkg::BK_INIT);

endmodule

// File: src/nibble_framebuffer_pixel_engine_core.sv
// nibble_framebuffer_pixel_engine_core: top level of the 4bpp framebuffer
// engine. Uses nfpe_pkg, nfpe_front, nfpe_queue and nfpe_back.

// A 128x128 screen of 4-bit pixels, two per byte (odd x in the high nibble),
// in one 8192-byte RAM. After reset the block sweeps the whole RAM to zero,
// one byte per cycle; in_ready stays low until that pass is
// done (palette writes are taken throughout). Each transfer on the input
// channel gives exactly one transfer on the output channel, in order. In the
// back end a set does one RAM read and then one merged write-back, a get a
// read and then takes the registered read data, a clipped or transparent set,
// a clipped get or an unused request code posts its result as it is taken,
// and a clear sweeps one byte per cycle over the single RAM write port. The front end classifies a request
// in the cycle it is taken and hands it through a 2-entry command queue, so
// requests keep coming in while the back end is busy or the result waits.
// Palette registers may be written only when the block is idle.

module nibble_framebuffer_pixel_engine_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [nfpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nfpe_pkg::PAL_W-1:0]          cfg_data,
    // requests
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [nfpe_pkg::REQ_W-1:0]          req_type,
    input  logic signed [nfpe_pkg::POS_W-1:0]   x_pos,
    input  logic signed [nfpe_pkg::POS_W-1:0]   y_pos,
    input  logic [nfpe_pkg::COLOR_W-1:0]        color_in,
    input  logic                                color_given,
    // results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [nfpe_pkg::COLOR_W-1:0]        pixel_value,
    output logic                                pixel_written
);

    nfpe_pkg::cmd_t                 front_cmd;
    nfpe_pkg::cmd_t                 head_cmd;
    nfpe_pkg::bk_status_t           bk_status;
    logic                           accept;
    logic                           q_empty, q_full, q_pop;
    logic [nfpe_pkg::Q_CNT_W-1:0]   q_count;

    // no request enters while the power-up sweep runs
    assign in_ready = !q_full && !bk_status.init_busy;
    assign accept   = in_valid && in_ready;

    nfpe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .req_type    (req_type),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .color_in    (color_in),
        .color_given (color_given),
        .cmd         (front_cmd)
    );

    nfpe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    nfpe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .q_empty       (q_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_value   (pixel_value),
        .pixel_written (pixel_written),
        .status        (bk_status)
    );

    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= nfpe_pkg::Q_CNT_W'(nfpe_pkg::Q_DEPTH))
        else $error("command queue count above depth");

    // the power-up sweep blocks new requests
    a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.init_busy |-> !in_ready)
        else $error("request taken during power-up sweep");

    // a write result never carries a read value
    a_written_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_written) |-> (pixel_value == '0))
        else $error("set result with nonzero pixel value");

    // a read-modify-write always finishes with a result on the next edge
    a_rmw_result: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_status.state == nfpe_pkg::BK_RMW) |=> (out_valid && pixel_written))
        else $error("read-modify-write did not post its result");

endmodule

// File: sim/nibble_framebuffer_pixel_engine_core_test.sv
// Self-checking testbench for nibble_framebuffer_pixel_engine_core: directed and random
// pixel traffic, palette changes and output back-pressure. Depends on nfpe_pkg and the core.
`timescale 1ns / 1ps

module nibble_framebuffer_pixel_engine_core_test;

    // Spare request code: the block must ignore it and answer with zeros
    localparam logic [nfpe_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Run limits. The worst case is at most 14 clears, plus the clearing pass after
    // reset, plus some 1700 transfers with sender gaps and receiver stalls.
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int RING_DEPTH    = 16;

    // Receiver stall modes
    localparam int RX_FREE    = 0;   // always ready
    localparam int RX_RANDOM  = 1;   // ready half the time
    localparam int RX_MOSTLY  = 2;   // ready nine times out of ten
    localparam int RX_PATTERN = 3;   // ready three times out of five, in a repeating pattern

    typedef struct packed {
        logic [nfpe_pkg::COLOR_W-1:0] value;
        logic                         written;
    } pixel_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [nfpe_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [nfpe_pkg::PAL_W-1:0]          cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic [nfpe_pkg::REQ_W-1:0]          req_type;
    logic signed [nfpe_pkg::POS_W-1:0]   x_pos;
    logic signed [nfpe_pkg::POS_W-1:0]   y_pos;
    logic [nfpe_pkg::COLOR_W-1:0]        color_in;
    logic                                color_given;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [nfpe_pkg::COLOR_W-1:0]        pixel_value;
    logic                                pixel_written;

    // Shadow copy of the screen, pen and draw palette
    logic [nfpe_pkg::BYTE_W-1:0]  screen_shadow [nfpe_pkg::SCREEN_BYTES];
    logic [nfpe_pkg::COLOR_W-1:0] pen_shadow;
    logic [nfpe_pkg::PAL_W-1:0]   draw_pal_low;
    logic [nfpe_pkg::PAL_W-1:0]   draw_pal_high;

    // Results still owed by the block, oldest first
    pixel_result_t pending_pixels[$];

    // Recent set coordinates, so that gets often land on drawn pixels
    logic signed [nfpe_pkg::POS_W-1:0] drawn_x [RING_DEPTH];
    logic signed [nfpe_pkg::POS_W-1:0] drawn_y [RING_DEPTH];
    int drawn_slot = 0;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int clears_left    = 12;   // clears are slow, keep random ones rare
    bit hold_pending   = 1'b0;
    int hold_left      = 0;
    int rx_mode        = RX_FREE;
    int rx_mode_left   = 0;
    int rx_phase       = 0;

    nibble_framebuffer_pixel_engine_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .color_in      (color_in),
        .color_given   (color_given),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_value   (pixel_value),
        .pixel_written (pixel_written)
    );

    always #5 clk = ~clk;

    // Hard stop on a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Apply one request to the shadow state and work out the result it owes.
    task automatic apply_pixel_request(
        input  logic [nfpe_pkg::REQ_W-1:0]        req,
        input  logic signed [nfpe_pkg::POS_W-1:0] x,
        input  logic signed [nfpe_pkg::POS_W-1:0] y,
        input  logic [nfpe_pkg::COLOR_W-1:0]      cin,
        input  logic                              given,
        output pixel_result_t                     res
    );
        logic [nfpe_pkg::COLOR_W-1:0] color;
        logic [nfpe_pkg::PAL_W-1:0]   pal_word;
        logic [nfpe_pkg::ENTRY_W-1:0] entry;
        logic                         on_screen;
        int                           xi;
        int                           yi;
        int                           offset;

        xi = int'(x);
        yi = int'(y);
        res = '0;
        on_screen = xi >= 0 && yi >= 0 &&
                    xi < nfpe_pkg::SCREEN_SIDE && yi < nfpe_pkg::SCREEN_SIDE;
        offset = yi * nfpe_pkg::ROW_BYTES + (xi >>> 1);
        case (req)
            nfpe_pkg::REQ_CLEAR:
            begin
                // no color given: fill with 0 and leave the pen alone
                color = given ? cin : '0;
                foreach (screen_shadow[i])
                    screen_shadow[i] = {color, color};
                if (given)
                    pen_shadow = color;
            end
            nfpe_pkg::REQ_SET:
            begin
                // pen follows the color even when clipped or transparent
                color = given ? cin : pen_shadow;
                pen_shadow = color;
                if (on_screen)
                begin
                    pal_word = color[nfpe_pkg::COLOR_W-1] ? draw_pal_high : draw_pal_low;
                    entry = pal_word[nfpe_pkg::ENTRY_W * color[nfpe_pkg::COLOR_W-2:0]
                                     +: nfpe_pkg::ENTRY_W];
                    if (!entry[nfpe_pkg::ENTRY_W-1])
                    begin
                        if (xi[0])
                            screen_shadow[offset][nfpe_pkg::BYTE_W-1:nfpe_pkg::COLOR_W] =
                                entry[nfpe_pkg::COLOR_W-1:0];
                        else
                            screen_shadow[offset][nfpe_pkg::COLOR_W-1:0] =
                                entry[nfpe_pkg::COLOR_W-1:0];
                        res.written = 1'b1;
                    end
                end
            end
            nfpe_pkg::REQ_GET:
            begin
                if (on_screen)
                    res.value = xi[0]
                        ? screen_shadow[offset][nfpe_pkg::BYTE_W-1:nfpe_pkg::COLOR_W]
                        : screen_shadow[offset][nfpe_pkg::COLOR_W-1:0];
            end
            default: ;
        endcase
    endtask

    // Offer one request and hold it until the transfer; valid stays high afterwards.
    task automatic send_request(
        input logic [nfpe_pkg::REQ_W-1:0]        req,
        input logic signed [nfpe_pkg::POS_W-1:0] x,
        input logic signed [nfpe_pkg::POS_W-1:0] y,
        input logic [nfpe_pkg::COLOR_W-1:0]      cin,
        input logic                              given
    );
        pixel_result_t res;

        in_valid    <= 1'b1;
        req_type    <= req;
        x_pos       <= x;
        y_pos       <= y;
        color_in    <= cin;
        color_given <= given;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_pixel_request(req, x, y, cin, given, res);
        pending_pixels.push_back(res);
        if (req == nfpe_pkg::REQ_SET)
        begin
            drawn_x[drawn_slot] = x;
            drawn_y[drawn_slot] = y;
            drawn_slot = (drawn_slot + 1) % RING_DEPTH;
        end
    endtask

    task automatic sender_gap(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both palette words, back to back; only call while the block is idle.
    task automatic write_palette(
        input logic [nfpe_pkg::PAL_W-1:0] low,
        input logic [nfpe_pkg::PAL_W-1:0] high
    );
        cfg_we    <= 1'b1;
        cfg_index <= nfpe_pkg::CFG_PALETTE_LOW;
        cfg_data  <= low;
        @(posedge clk);
        draw_pal_low = low;
        cfg_index <= nfpe_pkg::CFG_PALETTE_HIGH;
        cfg_data  <= high;
        @(posedge clk);
        draw_pal_high = high;
        cfg_we <= 1'b0;
    endtask

    // Mostly on-screen, some right at the borders, the rest anywhere in 16 bits
    function automatic logic signed [nfpe_pkg::POS_W-1:0] random_coord();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 70)
            return nfpe_pkg::POS_W'($urandom_range(0, nfpe_pkg::SCREEN_SIDE - 1));
        if (pick < 82)
        begin
            case ($urandom_range(0, 3))
                0:       return nfpe_pkg::POS_W'(-1);
                1:       return nfpe_pkg::POS_W'(0);
                2:       return nfpe_pkg::POS_W'(nfpe_pkg::SCREEN_SIDE - 1);
                default: return nfpe_pkg::POS_W'(nfpe_pkg::SCREEN_SIDE);
            endcase
        end
        return nfpe_pkg::POS_W'($urandom);
    endfunction

    task automatic send_random_request();
        logic [nfpe_pkg::REQ_W-1:0]        req;
        logic signed [nfpe_pkg::POS_W-1:0] x;
        logic signed [nfpe_pkg::POS_W-1:0] y;
        int                                pick;
        int                                slot;

        pick = $urandom_range(0, 199);
        x = random_coord();
        y = random_coord();
        if (pick < 3)
            req = REQ_UNUSED;
        else if (pick == 3 && clears_left > 0)
        begin
            req = nfpe_pkg::REQ_CLEAR;
            clears_left--;
        end
        else if (pick < 110)
            req = nfpe_pkg::REQ_SET;
        else
        begin
            req = nfpe_pkg::REQ_GET;
            // read back something recently drawn half the time
            if ($urandom_range(0, 1))
            begin
                slot = $urandom_range(0, RING_DEPTH - 1);
                x = drawn_x[slot];
                y = drawn_y[slot];
            end
        end
        send_request(req, x, y, nfpe_pkg::COLOR_W'($urandom), $urandom_range(0, 3) != 0);
    endtask

    // Random bursts with random gaps; some bursts run back to back
    task automatic send_random_traffic(input int count);
        int sent;
        int burst;

        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    send_random_request();
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                sender_gap($urandom_range(1, 12));
        end
    endtask

    // Edge values, both nibbles, pen handling, clipping, unused code and clears
    task automatic test_directed_cases();
        send_request(nfpe_pkg::REQ_GET,   0,      0,     4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_SET,   0,      0,     4'h5, 1'b0);   // pen still 0
        send_request(nfpe_pkg::REQ_SET,   1,      0,     4'hf, 1'b1);   // odd x, high nibble
        send_request(nfpe_pkg::REQ_SET,   0,      0,     4'ha, 1'b1);
        send_request(nfpe_pkg::REQ_GET,   0,      0,     4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_GET,   1,      0,     4'h0, 1'b1);
        send_request(nfpe_pkg::REQ_SET,   127,    127,   4'h7, 1'b1);
        send_request(nfpe_pkg::REQ_GET,   127,    127,   4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_SET,   128,    5,     4'h3, 1'b1);   // clipped, pen moves
        send_request(nfpe_pkg::REQ_SET,   5,      5,     4'h0, 1'b0);   // draws with pen 3
        send_request(nfpe_pkg::REQ_GET,   5,      5,     4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_SET,   -1,     0,     4'hc, 1'b1);
        send_request(nfpe_pkg::REQ_GET,   -32768, 32767, 4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_GET,   32767,  -1,    4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_GET,   127,    128,   4'h0, 1'b0);
        send_request(REQ_UNUSED,          -1,     -1,    4'hf, 1'b1);
        send_request(nfpe_pkg::REQ_CLEAR, 0,      0,     4'h9, 1'b1);
        send_request(nfpe_pkg::REQ_GET,   64,     33,    4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_SET,   2,      2,     4'h1, 1'b0);   // pen 9 from clear
        send_request(nfpe_pkg::REQ_CLEAR, -32768, 32767, 4'h6, 1'b0);   // fills 0, pen kept
        send_request(nfpe_pkg::REQ_GET,   3,      3,     4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_SET,   4,      4,     4'h0, 1'b0);
        send_request(nfpe_pkg::REQ_GET,   4,      4,     4'h0, 1'b0);
        wait_drain();
    endtask

    // Several palettes: all black, all transparent, random, random opaque, reset
    task automatic test_palette_settings();
        logic [nfpe_pkg::PAL_W-1:0] low;
        logic [nfpe_pkg::PAL_W-1:0] high;

        for (int setting = 0; setting < 5; setting++)
        begin
            case (setting)
                0:
                begin
                    low  = '0;
                    high = '0;
                end
                1:
                begin
                    low  = '1;
                    high = '1;
                end
                2:
                begin
                    low  = nfpe_pkg::PAL_W'({$urandom, $urandom});
                    high = nfpe_pkg::PAL_W'({$urandom, $urandom});
                end
                3:
                begin
                    low  = nfpe_pkg::PAL_W'({$urandom, $urandom});
                    high = nfpe_pkg::PAL_W'({$urandom, $urandom});
                    for (int e = 0; e < 8; e++)
                    begin
                        low[nfpe_pkg::ENTRY_W * e + nfpe_pkg::ENTRY_W - 1]  = 1'b0;
                        high[nfpe_pkg::ENTRY_W * e + nfpe_pkg::ENTRY_W - 1] = 1'b0;
                    end
                end
                default:
                begin
                    low  = nfpe_pkg::PAL_LOW_RESET;
                    high = nfpe_pkg::PAL_HIGH_RESET;
                end
            endcase
            write_palette(low, high);
            send_random_traffic(80);
            wait_drain();
        end
    endtask

    // Receiver holds off for a long stretch while transfers keep being offered,
    // so the command queue fills and in_ready drops.
    task automatic test_output_holdoff();
        hold_pending = 1'b1;
        repeat (40) send_random_request();
        wait_drain();
    endtask

    // Bulk random traffic, with a new random palette between chunks
    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            send_random_traffic(400);
            wait_drain();
            write_palette(nfpe_pkg::PAL_W'({$urandom, $urandom}),
                          nfpe_pkg::PAL_W'({$urandom, $urandom}));
        end
    endtask

    // Receiver: a stall mode that changes now and then, plus the long hold-off
    always @(posedge clk)
    begin
        if (hold_pending)
        begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(RX_FREE, RX_PATTERN);
            rx_mode_left = $urandom_range(32, 200);
        end
        rx_mode_left--;
        rx_phase = (rx_phase + 1) % 5;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_RANDOM:  out_ready <= $urandom_range(0, 1) != 0;
                RX_MOSTLY:  out_ready <= $urandom_range(0, 9) != 0;
                RX_PATTERN: out_ready <= rx_phase < 3;
                default:    out_ready <= 1'b1;
            endcase
        end
    end

    // Each output transfer is checked against the oldest owed result
    always @(posedge clk)
    begin : check_results
        pixel_result_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual value %0h written %0b",
                         $time, pixel_value, pixel_written);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_value !== want.value)
                begin
                    $display("%0t: pixel_value mismatch: expected %0h, actual %0h",
                             $time, want.value, pixel_value);
                    mismatch_count++;
                end
                if (pixel_written !== want.written)
                begin
                    $display("%0t: pixel_written mismatch: expected %0b, actual %0b",
                             $time, want.written, pixel_written);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        req_type    <= '0;
        x_pos       <= '0;
        y_pos       <= '0;
        color_in    <= '0;
        color_given <= 1'b0;
        foreach (screen_shadow[i])
            screen_shadow[i] = '0;
        foreach (drawn_x[i])
        begin
            drawn_x[i] = '0;
            drawn_y[i] = '0;
        end
        pen_shadow    = '0;
        draw_pal_low  = nfpe_pkg::PAL_LOW_RESET;
        draw_pal_high = nfpe_pkg::PAL_HIGH_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // in_ready stays low through the clearing pass; send_request waits it out
        test_directed_cases();
        test_palette_settings();
        test_output_holdoff();
        test_random_traffic();

        wait_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/nfpe_pkg.sv
src/nfpe_ram.sv
src/nfpe_front.sv
src/nfpe_queue.sv
src/nfpe_back.sv
src/nibble_framebuffer_pixel_engine_core.sv
sim/nibble_framebuffer_pixel_engine_core_test.sv
